@@ rtl/core/websocket_frame_deframer_assert.svh @@
// Assertion macros shared by the deframer checker.
`ifndef WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH
`define WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define WSDF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define WSDF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/wsdf_pkg.sv @@
// ----------------------------------------------------------------------------
// wsdf_pkg
// Types and constants of the WebSocket frame deframer.
// ----------------------------------------------------------------------------
package wsdf_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       new_connection;
	} wsdf_in_t;

	typedef struct packed {
		logic [7:0] payload_byte;
		logic [1:0] kind;
		logic       last_of_message;
		logic       empty_message;
		logic       frame_error;
	} wsdf_out_t;

	typedef enum logic [4:0] {
		PH_HDR0    = 5'b00001,
		PH_HDR1    = 5'b00010,
		PH_EXTLEN  = 5'b00100,
		PH_MASK    = 5'b01000,
		PH_PAYLOAD = 5'b10000
	} wsdf_phase_t;

	localparam logic [3:0] OP_TEXT   = 4'h1;
	localparam logic [3:0] OP_BINARY = 4'h2;
	localparam logic [3:0] OP_CLOSE  = 4'h8;
	localparam logic [3:0] OP_PING   = 4'h9;

	localparam logic [1:0] KIND_TEXT   = 2'd0;
	localparam logic [1:0] KIND_BINARY = 2'd1;
	localparam logic [1:0] KIND_PING   = 2'd2;
	localparam logic [1:0] KIND_CLOSE  = 2'd3;

	localparam logic [6:0] LEN16_CODE = 7'd126;
	localparam logic [6:0] LEN64_CODE = 7'd127;

	localparam logic [3:0] EXT16_BYTES = 4'd2;
	localparam logic [3:0] EXT64_BYTES = 4'd8;
	localparam logic [3:0] MASK_BYTES  = 4'd4;

	localparam logic [31:0] MAX_LEN_RESET = 32'd65536;

endpackage

@@ rtl/core/websocket_frame_deframer.sv @@
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// Receive-side WebSocket frame parser for one connection: header, extended
// length, mask key, unmasked payload bytes with kind and last flags.
// ----------------------------------------------------------------------------
// Takes one stream byte per clock while in_stall is low and gives at most one
// result per byte. A byte is captured in the input register when it transfers
// and is parsed there in one pass of logic into the result register, which
// loads only while the result side is not stalled; the 64-bit length decrement
// and limit compare set the path. in_stall rises only while a result waits in
// the result register and a parsed byte waits in the input register.
module websocket_frame_deframer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  wsdf_pkg::wsdf_in_t in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output wsdf_pkg::wsdf_out_t out_data,
	input  logic               cfg_wr_en,
	input  logic [31:0]        cfg_wr_data
);

	logic                  in_valid_s1;
	wsdf_pkg::wsdf_in_t    in_data_s1;
	logic                  advance;

	logic [31:0]           max_len_q;
	wsdf_pkg::wsdf_phase_t phase_q, phase_d;
	logic                  fin_q, fin_d;
	logic [3:0]            op_q, op_d;
	logic                  mask_q, mask_d;
	logic [3:0]            hcnt_q, hcnt_d;
	logic [63:0]           rem_q, rem_d;
	logic [1:0]            idx_q, idx_d;
	logic [31:0]           key_q, key_d;
	logic                  closed_q, closed_d;

	logic                  res_valid;
	wsdf_pkg::wsdf_out_t   res;
	logic                  out_valid_q;
	wsdf_pkg::wsdf_out_t   out_data_q;

	logic                  emit;
	logic [1:0]            emit_kind;
	logic [1:0]            pl_idx;
	logic [7:0]            key_byte;
	logic [63:0]           rem_dec;
	logic                  len_known;
	logic                  begin_pl;
	logic                  close_last;

	assign advance   = in_valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = in_valid_s1 && !advance;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_comb begin
		phase_d    = phase_q;
		fin_d      = fin_q;
		op_d       = op_q;
		mask_d     = mask_q;
		hcnt_d     = hcnt_q;
		rem_d      = rem_q;
		idx_d      = idx_q;
		key_d      = key_q;
		closed_d   = closed_q;
		res_valid  = 1'b0;
		res        = '0;
		len_known  = 1'b0;
		begin_pl   = 1'b0;
		close_last = 1'b0;

		if (in_data_s1.new_connection) begin
			phase_d  = wsdf_pkg::PH_HDR0;
			fin_d    = 1'b0;
			op_d     = '0;
			mask_d   = 1'b0;
			hcnt_d   = '0;
			rem_d    = '0;
			idx_d    = '0;
			key_d    = '0;
			closed_d = 1'b0;
		end

		emit      = fin_d;
		emit_kind = wsdf_pkg::KIND_TEXT;
		case (op_d)
			wsdf_pkg::OP_TEXT:   emit_kind = wsdf_pkg::KIND_TEXT;
			wsdf_pkg::OP_BINARY: emit_kind = wsdf_pkg::KIND_BINARY;
			wsdf_pkg::OP_PING:   emit_kind = wsdf_pkg::KIND_PING;
			wsdf_pkg::OP_CLOSE:  emit_kind = wsdf_pkg::KIND_CLOSE;
			default:             emit      = 1'b0;
		endcase

		pl_idx = idx_d;
		case (pl_idx)
			2'd0:    key_byte = key_d[31:24];
			2'd1:    key_byte = key_d[23:16];
			2'd2:    key_byte = key_d[15:8];
			default: key_byte = key_d[7:0];
		endcase
		rem_dec = rem_d - 64'd1;

		if (!closed_d) begin
			case (phase_d)
				wsdf_pkg::PH_HDR0: begin
					fin_d   = in_data_s1.data_byte[7];
					op_d    = in_data_s1.data_byte[3:0];
					phase_d = wsdf_pkg::PH_HDR1;
				end
				wsdf_pkg::PH_HDR1: begin
					mask_d = in_data_s1.data_byte[7];
					key_d  = '0;
					rem_d  = '0;
					if (in_data_s1.data_byte[6:0] == wsdf_pkg::LEN16_CODE) begin
						hcnt_d  = wsdf_pkg::EXT16_BYTES;
						phase_d = wsdf_pkg::PH_EXTLEN;
					end else if (in_data_s1.data_byte[6:0] == wsdf_pkg::LEN64_CODE) begin
						hcnt_d  = wsdf_pkg::EXT64_BYTES;
						phase_d = wsdf_pkg::PH_EXTLEN;
					end else begin
						rem_d     = {57'd0, in_data_s1.data_byte[6:0]};
						len_known = 1'b1;
					end
				end
				wsdf_pkg::PH_EXTLEN: begin
					rem_d  = {rem_d[55:0], in_data_s1.data_byte};
					hcnt_d = hcnt_d - 4'd1;
					if (hcnt_d == 4'd0) begin
						len_known = 1'b1;
					end
				end
				wsdf_pkg::PH_MASK: begin
					key_d  = {key_d[23:0], in_data_s1.data_byte};
					hcnt_d = hcnt_d - 4'd1;
					if (hcnt_d == 4'd0) begin
						begin_pl = 1'b1;
					end
				end
				wsdf_pkg::PH_PAYLOAD: begin
					rem_d = rem_dec;
					idx_d = pl_idx + 2'd1;
					if (rem_dec == 64'd0) begin
						phase_d = wsdf_pkg::PH_HDR0;
					end
					if (emit) begin
						res_valid        = 1'b1;
						res.payload_byte = in_data_s1.data_byte ^ key_byte;
						res.kind         = emit_kind;
						if (emit_kind == wsdf_pkg::KIND_CLOSE) begin
							close_last          = (rem_dec == 64'd0) || (pl_idx == 2'd1);
							res.last_of_message = close_last;
							if (close_last) begin
								closed_d = 1'b1;
							end
						end else begin
							res.last_of_message = (rem_dec == 64'd0);
						end
					end
				end
				default: begin
					phase_d = wsdf_pkg::PH_HDR0;
				end
			endcase

			if (len_known) begin
				if (rem_d[63:32] != 32'd0 || rem_d[31:0] > max_len_q) begin
					closed_d        = 1'b1;
					phase_d         = wsdf_pkg::PH_HDR0;
					res_valid       = 1'b1;
					res.frame_error = 1'b1;
				end else if (mask_d) begin
					phase_d = wsdf_pkg::PH_MASK;
					hcnt_d  = wsdf_pkg::MASK_BYTES;
				end else begin
					begin_pl = 1'b1;
				end
			end

			if (begin_pl) begin
				idx_d = '0;
				if (rem_d != 64'd0) begin
					phase_d = wsdf_pkg::PH_PAYLOAD;
				end else begin
					phase_d = wsdf_pkg::PH_HDR0;
					if (emit) begin
						res_valid           = 1'b1;
						res.kind            = emit_kind;
						res.last_of_message = 1'b1;
						res.empty_message   = 1'b1;
						if (emit_kind == wsdf_pkg::KIND_CLOSE) begin
							closed_d = 1'b1;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			in_valid_s1 <= 1'b1;
		end else if (advance) begin
			in_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			in_data_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= wsdf_pkg::MAX_LEN_RESET;
		end else if (cfg_wr_en) begin
			max_len_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= wsdf_pkg::PH_HDR0;
			fin_q    <= 1'b0;
			op_q     <= '0;
			mask_q   <= 1'b0;
			hcnt_q   <= '0;
			rem_q    <= '0;
			idx_q    <= '0;
			key_q    <= '0;
			closed_q <= 1'b0;
		end else if (advance) begin
			phase_q  <= phase_d;
			fin_q    <= fin_d;
			op_q     <= op_d;
			mask_q   <= mask_d;
			hcnt_q   <= hcnt_d;
			rem_q    <= rem_d;
			idx_q    <= idx_d;
			key_q    <= key_d;
			closed_q <= closed_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res_valid;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			out_data_q <= res;
		end
	end

endmodule

@@ rtl/core/wsdf_checker.sv @@
// ----------------------------------------------------------------------------
// wsdf_checker
// Port-level checks of the deframer, bound to the top level.
// ----------------------------------------------------------------------------
`include "websocket_frame_deframer_assert.svh"

module wsdf_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input wsdf_pkg::wsdf_in_t  in_data,
	input logic                out_valid,
	input logic                out_stall,
	input wsdf_pkg::wsdf_out_t out_data
);

	logic in_xfer;

	assign in_xfer = in_valid && !in_stall;

	`WSDF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data),
		"stalled result changed")
	`WSDF_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(in_data),
		"stalled input transfer changed")
	`WSDF_ASSERT_NOW(a_in_stall_cause, in_stall, out_valid && out_stall,
		"input stalled while result side free")
	`WSDF_ASSERT_NOW(a_out_from_in, $rose(out_valid), $past(in_xfer, 2),
		"result without a byte transfer two cycles earlier")
	`WSDF_ASSERT_NOW(a_empty_marker, out_valid && out_data.empty_message,
		out_data.last_of_message && (out_data.payload_byte == 8'd0) && !out_data.frame_error,
		"empty marker malformed")

endmodule

bind websocket_frame_deframer wsdf_checker u_wsdf_checker (.*);
